@@ rtl/core/fcks_pkg.sv @@
// Shared types and constants for the canonical k-mer stream block.
package fcks_pkg;

  localparam int unsigned PositionBits = 48;
  localparam int unsigned KmerBits     = 64;
  localparam int unsigned OutPosBits   = 48;
  localparam int unsigned KBits        = 6;
  localparam int unsigned RunBits      = 6;
  localparam int unsigned BaseSlots    = KmerBits / 2;

  localparam logic [KBits-1:0] KReset = KBits'(21);
  localparam logic [KBits-1:0] KMin   = KBits'(1);
  localparam logic [KBits-1:0] KMax   = KBits'(BaseSlots);

  localparam logic [7:0] CharHeader = 8'h3E;
  localparam logic [7:0] CharLf     = 8'h0A;
  localparam logic [7:0] CharCr     = 8'h0D;
  localparam logic [7:0] CharUpA    = 8'h41;
  localparam logic [7:0] CharUpC    = 8'h43;
  localparam logic [7:0] CharUpG    = 8'h47;
  localparam logic [7:0] CharUpT    = 8'h54;
  localparam logic [7:0] CharLowA   = 8'h61;
  localparam logic [7:0] CharLowC   = 8'h63;
  localparam logic [7:0] CharLowG   = 8'h67;
  localparam logic [7:0] CharLowT   = 8'h74;

  localparam logic [1:0] CodeA = 2'd0;
  localparam logic [1:0] CodeC = 2'd1;
  localparam logic [1:0] CodeG = 2'd2;
  localparam logic [1:0] CodeT = 2'd3;

  typedef enum logic [2:0] {
    KIND_BASE,
    KIND_HDR,
    KIND_LF,
    KIND_CR,
    KIND_BAD
  } byte_kind_e;

  typedef struct packed {
    logic       valid;
    byte_kind_e kind;
    logic [1:0] code;
  } stage_t;

endpackage

@@ rtl/core/fcks_ifs.sv @@
// Handshake interfaces for the text, k-mer and configuration channels.
interface fcks_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

interface fcks_kmer_if;
  logic                                valid;
  logic                                ready;
  logic [fcks_pkg::KmerBits-1:0]       canonical_kmer;
  logic [fcks_pkg::OutPosBits-1:0]     kmer_start;

  modport source (output valid, output canonical_kmer, output kmer_start, input ready);
  modport sink (input valid, input canonical_kmer, input kmer_start, output ready);
endinterface

interface fcks_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [fcks_pkg::KBits-1:0]    kmer_len;

  modport source (output valid, output kmer_len, input ready);
  modport sink (input valid, input kmer_len, output ready);
endinterface

@@ rtl/core/fasta_canonical_kmer_stream.sv @@
// Top level: input register, k-mer size register and rolling k-mer core.
// An accepted text word passes through the input register and then the result register, which drives kmer_o.
// Throughput: 1 text word per cycle; the only stall is a held word on kmer_o.
// The input register and the result register each hold one word.
// Reset clears the rolling state, position, header flag and both valid flags,
// and sets k to 21; it takes effect at once with no clearing pass.
module fasta_canonical_kmer_stream (
  input  logic               clk_i,
  input  logic               rst_ni,
  fcks_byte_if.sink          text_i,
  fcks_kmer_if.source        kmer_o,
  fcks_cfg_if.sink           cfg_i
);

  logic [fcks_pkg::KBits-1:0] k_q, k_d;
  fcks_pkg::stage_t           stage_q, stage_d;
  fcks_pkg::byte_kind_e       kind;
  logic [1:0]                 code;
  logic                       advance;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    k_d = k_q;
    if (cfg_i.valid) begin
      if (cfg_i.kmer_len == '0) begin
        k_d = fcks_pkg::KMin;
      end else if (cfg_i.kmer_len > fcks_pkg::KMax) begin
        k_d = fcks_pkg::KMax;
      end else begin
        k_d = cfg_i.kmer_len;
      end
    end
  end

  fcks_classify u_classify (
    .text_byte_i (text_i.text_byte),
    .kind_o      (kind),
    .code_o      (code)
  );

  assign text_i.ready = !stage_q.valid || advance;

  always_comb begin
    stage_d = stage_q;
    if (text_i.ready) begin
      stage_d.valid = text_i.valid;
      stage_d.kind  = kind;
      stage_d.code  = code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= fcks_pkg::KReset;
      stage_q <= '0;
    end else begin
      k_q     <= k_d;
      stage_q <= stage_d;
    end
  end

  fcks_roll u_roll (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .stage_i          (stage_q),
    .kmer_len_i       (k_q),
    .kmer_ready_i     (kmer_o.ready),
    .advance_o        (advance),
    .kmer_valid_o     (kmer_o.valid),
    .canonical_kmer_o (kmer_o.canonical_kmer),
    .kmer_start_o     (kmer_o.kmer_start)
  );

endmodule

@@ rtl/core/fcks_classify.sv @@
// Byte decoder: sorts a FASTA text byte into header, line end, base or bad.
module fcks_classify (
  input  logic [7:0]           text_byte_i,
  output fcks_pkg::byte_kind_e kind_o,
  output logic [1:0]           code_o
);

  always_comb begin
    kind_o = fcks_pkg::KIND_BASE;
    code_o = fcks_pkg::CodeA;
    unique case (text_byte_i) inside
      fcks_pkg::CharHeader: kind_o = fcks_pkg::KIND_HDR;
      fcks_pkg::CharLf:     kind_o = fcks_pkg::KIND_LF;
      fcks_pkg::CharCr:     kind_o = fcks_pkg::KIND_CR;
      fcks_pkg::CharUpA, fcks_pkg::CharLowA: code_o = fcks_pkg::CodeA;
      fcks_pkg::CharUpC, fcks_pkg::CharLowC: code_o = fcks_pkg::CodeC;
      fcks_pkg::CharUpG, fcks_pkg::CharLowG: code_o = fcks_pkg::CodeG;
      fcks_pkg::CharUpT, fcks_pkg::CharLowT: code_o = fcks_pkg::CodeT;
      default: kind_o = fcks_pkg::KIND_BAD;
    endcase
  end

endmodule

@@ rtl/core/fcks_roll.sv @@
// Rolling k-mer state, canonical selection and result register.
module fcks_roll (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fcks_pkg::stage_t                  stage_i,
  input  logic [fcks_pkg::KBits-1:0]        kmer_len_i,
  input  logic                              kmer_ready_i,
  output logic                              advance_o,
  output logic                              kmer_valid_o,
  output logic [fcks_pkg::KmerBits-1:0]     canonical_kmer_o,
  output logic [fcks_pkg::OutPosBits-1:0]   kmer_start_o
);

  logic [fcks_pkg::KmerBits-1:0]     fwd_q, fwd_d, rev_q, rev_d;
  logic [fcks_pkg::RunBits-1:0]      run_q, run_d;
  logic                              hdr_q, hdr_d;
  logic [fcks_pkg::PositionBits-1:0] pos_q, pos_d;
  logic                              out_valid_q, out_valid_d;
  logic [fcks_pkg::KmerBits-1:0]     kmer_q, kmer_d;
  logic [fcks_pkg::OutPosBits-1:0]   start_q, start_d;

  logic                              proc;
  logic                              emit;
  logic [fcks_pkg::KmerBits-1:0]     mask;
  logic [fcks_pkg::KmerBits-1:0]     rev_ins;
  logic [fcks_pkg::KBits-1:0]        k_less;

  assign advance_o = !out_valid_q || kmer_ready_i;
  assign proc      = stage_i.valid && advance_o;
  assign k_less    = kmer_len_i - fcks_pkg::KBits'(1);

  always_comb begin
    for (int i = 0; i < fcks_pkg::BaseSlots; i++) begin
      mask[2*i +: 2] = {2{fcks_pkg::KBits'(i) < kmer_len_i}};
    end
  end

  assign rev_ins = fcks_pkg::KmerBits'(2'd3 - stage_i.code) << {k_less, 1'b0};

  always_comb begin
    fwd_d   = fwd_q;
    rev_d   = rev_q;
    run_d   = run_q;
    hdr_d   = hdr_q;
    pos_d   = pos_q;
    emit    = 1'b0;
    if (proc) begin
      if (stage_i.kind == fcks_pkg::KIND_HDR) begin
        fwd_d = '0;
        rev_d = '0;
        run_d = '0;
        hdr_d = 1'b1;
      end else if (hdr_q) begin
        if (stage_i.kind == fcks_pkg::KIND_LF) begin
          hdr_d = 1'b0;
        end
      end else begin
        unique case (stage_i.kind)
          fcks_pkg::KIND_BASE: begin
            fwd_d = ({fwd_q[fcks_pkg::KmerBits-3:0], stage_i.code}) & mask;
            rev_d = (rev_q >> 2) | rev_ins;
            if (run_q != '1) begin
              run_d = run_q + fcks_pkg::RunBits'(1);
            end
            if (pos_q != '1) begin
              pos_d = pos_q + fcks_pkg::PositionBits'(1);
            end
            emit = run_d >= fcks_pkg::RunBits'(kmer_len_i);
          end
          fcks_pkg::KIND_BAD: begin
            fwd_d = '0;
            rev_d = '0;
            run_d = '0;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance_o) begin
      out_valid_d = emit;
    end
    kmer_d  = (fwd_d < rev_d) ? fwd_d : rev_d;
    start_d = fcks_pkg::OutPosBits'(pos_d - fcks_pkg::PositionBits'(kmer_len_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q       <= '0;
      rev_q       <= '0;
      run_q       <= '0;
      hdr_q       <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fwd_q       <= fwd_d;
      rev_q       <= rev_d;
      run_q       <= run_d;
      hdr_q       <= hdr_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kmer_q  <= kmer_d;
      start_q <= start_d;
    end
  end

  assign kmer_valid_o     = out_valid_q;
  assign canonical_kmer_o = kmer_q;
  assign kmer_start_o     = start_q;

`ifndef NO_ASSERTIONS
  a_hdr_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && stage_i.kind == fcks_pkg::KIND_HDR |=>
      fwd_q == '0 && rev_q == '0 && run_q == '0 && hdr_q)
    else $error("header start did not clear rolling state");

  a_pos_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> pos_q >= $past(pos_q))
    else $error("base position moved backward");

  a_out_has_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> run_q != '0)
    else $error("result word held with empty run");

  a_hdr_no_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && hdr_q && stage_i.kind != fcks_pkg::KIND_HDR |=> !out_valid_q)
    else $error("result produced inside header");
`endif

endmodule

@@ sim/fcks_kmer_monitor.sv @@
// Channel monitor: predicts canonical k-mer words from accepted text and compares results.
module fcks_kmer_monitor (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            text_valid_i,
  input  logic                            text_ready_i,
  input  logic [7:0]                      text_byte_i,
  input  logic                            kmer_valid_i,
  input  logic                            kmer_ready_i,
  input  logic [fcks_pkg::KmerBits-1:0]   canonical_kmer_i,
  input  logic [fcks_pkg::OutPosBits-1:0] kmer_start_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [fcks_pkg::KBits-1:0]      cfg_kmer_len_i,
  output int                              mismatch_count_o,
  output int                              kmers_awaited_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [fcks_pkg::KmerBits-1:0]   canonical_kmer;
    logic [fcks_pkg::OutPosBits-1:0] kmer_start;
  } kmer_word_t;

  kmer_word_t                        awaited_kmers [$];
  logic [fcks_pkg::KmerBits-1:0]     fwd_word;
  logic [fcks_pkg::KmerBits-1:0]     rev_word;
  logic [fcks_pkg::RunBits-1:0]      base_run;
  logic                              header_open;
  logic [fcks_pkg::PositionBits-1:0] base_count;
  logic [fcks_pkg::KBits-1:0]        kmer_len_q;

  task automatic clear_roll();
    fwd_word = '0;
    rev_word = '0;
    base_run = '0;
  endtask

  task automatic roll_text_byte(input logic [7:0] b);
    logic [fcks_pkg::KBits-1:0]    k;
    logic [fcks_pkg::KmerBits-1:0] mask;
    logic [1:0]                    code;
    logic                          is_base;
    kmer_word_t                    w;
    k = (kmer_len_q == '0) ? fcks_pkg::KMin :
        ((kmer_len_q > fcks_pkg::KMax) ? fcks_pkg::KMax : kmer_len_q);
    if (b == fcks_pkg::CharHeader) begin
      clear_roll();
      header_open = 1'b1;
      return;
    end
    if (header_open) begin
      if (b == fcks_pkg::CharLf) header_open = 1'b0;
      return;
    end
    if (b == fcks_pkg::CharLf || b == fcks_pkg::CharCr) return;
    is_base = 1'b1;
    code = fcks_pkg::CodeA;
    case (b)
      fcks_pkg::CharUpA, fcks_pkg::CharLowA: code = fcks_pkg::CodeA;
      fcks_pkg::CharUpC, fcks_pkg::CharLowC: code = fcks_pkg::CodeC;
      fcks_pkg::CharUpG, fcks_pkg::CharLowG: code = fcks_pkg::CodeG;
      fcks_pkg::CharUpT, fcks_pkg::CharLowT: code = fcks_pkg::CodeT;
      default: is_base = 1'b0;
    endcase
    if (!is_base) begin
      clear_roll();
      return;
    end
    mask = (k == fcks_pkg::KMax) ? '1 : ((64'd1 << (2 * k)) - 64'd1);
    fwd_word = ((fwd_word << 2) | fcks_pkg::KmerBits'(code)) & mask;
    rev_word = (rev_word >> 2) |
               (fcks_pkg::KmerBits'(fcks_pkg::CodeT - code) << (2 * (k - 1)));
    if (base_run != '1) base_run = base_run + 1'b1;
    if (base_count != '1) base_count = base_count + 1'b1;
    if (base_run < k) return;
    w.canonical_kmer = (fwd_word < rev_word) ? fwd_word : rev_word;
    w.kmer_start = fcks_pkg::OutPosBits'(base_count - fcks_pkg::PositionBits'(k));
    awaited_kmers.insert(awaited_kmers.size(), w);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    kmer_word_t w;
    if (!rst_ni) begin
      clear_roll();
      header_open = 1'b0;
      base_count = '0;
      kmer_len_q = fcks_pkg::KReset;
      awaited_kmers.delete();
      mismatch_count_o <= 0;
      kmers_awaited_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) kmer_len_q = cfg_kmer_len_i;
      if (text_valid_i && text_ready_i) roll_text_byte(text_byte_i);
      if (kmer_valid_i && kmer_ready_i) begin
        if (awaited_kmers.size() == 0) begin
          $display("%0t: unexpected k-mer word %h start %h", $time, canonical_kmer_i,
                   kmer_start_i);
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          w = awaited_kmers.pop_front();
          if (canonical_kmer_i !== w.canonical_kmer || kmer_start_i !== w.kmer_start) begin
            if (canonical_kmer_i !== w.canonical_kmer)
              $display("%0t: canonical_kmer expected %h, got %h", $time, w.canonical_kmer,
                       canonical_kmer_i);
            if (kmer_start_i !== w.kmer_start)
              $display("%0t: kmer_start expected %h, got %h", $time, w.kmer_start,
                       kmer_start_i);
            mismatch_count_o <= mismatch_count_o + 1;
          end
        end
      end
      kmers_awaited_o <= awaited_kmers.size();
    end
  end

endmodule

@@ sim/tb_fasta_canonical_kmer_stream.sv @@
// Testbench top: drives FASTA text and k-mer size writes, stalls results, reports the verdict.
module tb_fasta_canonical_kmer_stream;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i;
  logic rst_ni;
  int   mismatch_count;
  int   kmers_awaited;
  int   idle_pct;

  fcks_byte_if text_if ();
  fcks_kmer_if kmer_if ();
  fcks_cfg_if  cfg_if ();

  fasta_canonical_kmer_stream uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .text_i (text_if),
    .kmer_o (kmer_if),
    .cfg_i  (cfg_if)
  );

  fcks_kmer_monitor monitor (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .text_valid_i     (text_if.valid),
    .text_ready_i     (text_if.ready),
    .text_byte_i      (text_if.text_byte),
    .kmer_valid_i     (kmer_if.valid),
    .kmer_ready_i     (kmer_if.ready),
    .canonical_kmer_i (kmer_if.canonical_kmer),
    .kmer_start_i     (kmer_if.kmer_start),
    .cfg_valid_i      (cfg_if.valid),
    .cfg_ready_i      (cfg_if.ready),
    .cfg_kmer_len_i   (cfg_if.kmer_len),
    .mismatch_count_o (mismatch_count),
    .kmers_awaited_o  (kmers_awaited)
  );

  logic [7:0] base_chars [8] = '{fcks_pkg::CharUpA, fcks_pkg::CharUpC,
                                 fcks_pkg::CharUpG, fcks_pkg::CharUpT,
                                 fcks_pkg::CharLowA, fcks_pkg::CharLowC,
                                 fcks_pkg::CharLowG, fcks_pkg::CharLowT};

  logic [7:0] opening_text [23] = '{
    fcks_pkg::CharHeader, 8'h68, fcks_pkg::CharHeader, fcks_pkg::CharCr, fcks_pkg::CharLf,
    fcks_pkg::CharUpA, fcks_pkg::CharUpC, fcks_pkg::CharUpG, fcks_pkg::CharUpT,
    fcks_pkg::CharLowA, fcks_pkg::CharLowC, fcks_pkg::CharLowG, fcks_pkg::CharLowT,
    8'h4E, fcks_pkg::CharUpG, fcks_pkg::CharCr, fcks_pkg::CharLf,
    fcks_pkg::CharUpC, 8'h00, fcks_pkg::CharUpT, 8'hFF, fcks_pkg::CharUpA, fcks_pkg::CharUpA
  };

  logic [fcks_pkg::KBits-1:0] k_plan [9] = '{fcks_pkg::KMax, fcks_pkg::KMin, 6'd0, 6'd63,
                                             6'd33, fcks_pkg::KReset, 6'd0, 6'd0, 6'd5};

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    kmer_if.ready <= (idle_pct == 0) || ($urandom_range(0, 99) >= idle_pct);
  end

  task automatic send_word(input logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      text_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    text_if.valid     <= 1'b1;
    text_if.text_byte <= b;
    do @(posedge clk_i); while (!text_if.ready);
  endtask

  task automatic write_kmer_len(input logic [fcks_pkg::KBits-1:0] k);
    text_if.valid <= 1'b0;
    @(posedge clk_i);
    while (kmers_awaited != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_if.valid    <= 1'b1;
    cfg_if.kmer_len <= k;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_record(input int unsigned n_bases);
    int unsigned r;
    if ($urandom_range(0, 4) != 0) begin
      send_word(fcks_pkg::CharHeader);
      repeat ($urandom_range(0, 6)) send_word(8'($urandom_range(32, 126)));
      if ($urandom_range(0, 3) == 0) send_word(fcks_pkg::CharCr);
      send_word(fcks_pkg::CharLf);
    end
    for (int unsigned i = 0; i < n_bases; i++) begin
      r = $urandom_range(0, 99);
      if (r < 90) send_word(base_chars[$urandom_range(0, 7)]);
      else if (r < 94) send_word(fcks_pkg::CharLf);
      else if (r < 96) send_word(fcks_pkg::CharCr);
      else if (r < 98) send_word(8'h4E);
      else send_word(8'($urandom));
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned n;
    rst_ni           <= 1'b0;
    idle_pct         = 11;
    text_if.valid    <= 1'b0;
    text_if.text_byte <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.kmer_len  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_kmer_len(6'd2);
    foreach (opening_text[i]) send_word(opening_text[i]);

    for (int p = 0; p < 9; p++) begin
      if (p == 6 || p == 7) k_plan[p] = fcks_pkg::KBits'($urandom_range(2, 31));
      write_kmer_len(k_plan[p]);
      idle_pct = (p == 3) ? 0 : 11;
      sent = 0;
      while (sent < 145) begin
        n = $urandom_range(10, 80);
        send_record(n);
        sent += n;
      end
    end

    text_if.valid <= 1'b0;
    @(posedge clk_i);
    while (kmers_awaited != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && kmers_awaited == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule

@@ fasta_canonical_kmer_stream.f @@
rtl/core/fcks_pkg.sv
rtl/core/fcks_ifs.sv
rtl/core/fcks_classify.sv
rtl/core/fcks_roll.sv
rtl/core/fasta_canonical_kmer_stream.sv
sim/fcks_kmer_monitor.sv
sim/tb_fasta_canonical_kmer_stream.sv
